// ===== rtl/frs_pkg.sv =====
// ----------------------------------------------------------------------------
// frs_pkg
// Shared constants, types and the CRC-16 byte step for the frame receiver.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = 39;
    localparam int HDR_BYTES   = 5;
    localparam int OVERHEAD    = 7;
    localparam int RES_DEPTH   = 32;
    localparam int STORE_AW    = 6;
    localparam int RES_AW      = 5;
    localparam int LIM_CAP     = (MAX_PAYLOAD < STORE_DEPTH - OVERHEAD) ?
                                 MAX_PAYLOAD : STORE_DEPTH - OVERHEAD;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // configuration register indexes
    localparam logic REG_START_BYTE    = 1'b0;
    localparam logic REG_PAYLOAD_LIMIT = 1'b1;

    // one buffered payload result
    typedef struct packed {
        logic [7:0] frame_version;
        logic [7:0] frame_type;
        logic [5:0] frame_length;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       payload_valid;
    } res_entry_t;

    // frame store access, logical indexes from the front
    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_idx;
        logic [7:0]          wr_data;
        logic [STORE_AW-1:0] rd_idx;
        logic                drop_en;
        logic [STORE_AW-1:0] drop_cnt;
    } store_req_t;

    // one byte of CRC-16, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/frs_if.sv =====
// ----------------------------------------------------------------------------
// frs_byte_if / frs_result_if
// Valid/ready channels for received bytes and for result beats.
// ----------------------------------------------------------------------------
interface frs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface frs_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  frame_version;
    logic [7:0]  frame_type;
    logic [5:0]  frame_length;
    logic [4:0]  byte_index;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        final_res;
    logic [31:0] resync_total;
    logic [31:0] good_total;
    logic [31:0] bad_total;

    modport source (output valid, output kind, output frame_version, output frame_type,
                    output frame_length, output byte_index, output payload_byte,
                    output payload_valid, output final_res, output resync_total,
                    output good_total, output bad_total, input ready);
    modport sink   (input valid, input kind, input frame_version, input frame_type,
                    input frame_length, input byte_index, input payload_byte,
                    input payload_valid, input final_res, input resync_total,
                    input good_total, input bad_total, output ready);
endinterface

// ===== rtl/frs_store.sv =====
// ----------------------------------------------------------------------------
// frs_store
// Circular frame store: logical index from a head pointer, one write and one
// registered read per cycle, front drop by moving the head.
// ----------------------------------------------------------------------------
module frs_store
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  frs_pkg::store_req_t           req,
    output logic [7:0]                    rd_data
);

    logic [7:0]                    mem [frs_pkg::STORE_DEPTH];
    logic [frs_pkg::STORE_AW-1:0]  head_reg;
    logic [frs_pkg::STORE_AW-1:0]  head_next;
    logic [7:0]                    rd_data_reg;

    // logical to physical, sum stays below twice the depth
    function automatic logic [frs_pkg::STORE_AW-1:0] phys(
        input logic [frs_pkg::STORE_AW-1:0] head,
        input logic [frs_pkg::STORE_AW-1:0] idx);
        logic [frs_pkg::STORE_AW:0] s;
        s = {1'b0, head} + {1'b0, idx};
        if (s >= (frs_pkg::STORE_AW+1)'(frs_pkg::STORE_DEPTH))
            s = s - (frs_pkg::STORE_AW+1)'(frs_pkg::STORE_DEPTH);
        return s[frs_pkg::STORE_AW-1:0];
    endfunction

    assign head_next = req.drop_en ? phys(head_reg, req.drop_cnt) : head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            head_reg <= '0;
        else
            head_reg <= head_next;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[phys(head_reg, req.wr_idx)] <= req.wr_data;
        rd_data_reg <= mem[phys(head_reg, req.rd_idx)];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/frs_resbuf.sv =====
// ----------------------------------------------------------------------------
// frs_resbuf
// Holds the payload results of one input until the counters are final.
// ----------------------------------------------------------------------------
module frs_resbuf
(
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [frs_pkg::RES_AW-1:0]  wr_addr,
    input  frs_pkg::res_entry_t         wr_data,
    input  logic [frs_pkg::RES_AW-1:0]  rd_addr,
    output frs_pkg::res_entry_t         rd_data
);

    frs_pkg::res_entry_t mem [frs_pkg::RES_DEPTH];
    frs_pkg::res_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/crc_frame_receiver_resync_unit.sv =====
// ----------------------------------------------------------------------------
// crc_frame_receiver_resync_unit
// Byte-serial deframer: start byte, header, length, payload, CRC-16 check,
// resync on leading junk, result beats after the counters settle.
// ----------------------------------------------------------------------------
//  channel  dir  beat
//  rx       in   one received byte
//  result   out  payload byte of a good frame, or the closing status beat
//  cfg_*    in   register write (0 start byte, 1 payload limit)
//
//  One byte at a time: rx.ready is high only while idle.
//  Each scan step reads the store once per cycle through one registered port;
//  a resync drop, a rejected length, a CRC check and the payload copy of a
//  good frame all go through it. Results then leave one beat at a time,
//  payload beats first and the status beat last, each held by result stalls.
//  Reset clears counters, fill and sequencer; store contents are not cleared.
// ----------------------------------------------------------------------------
module crc_frame_receiver_resync_unit
(
    input  logic        clk,
    input  logic        rst_n,
    frs_byte_if.sink    rx,
    frs_result_if.source result,
    input  logic        cfg_we,
    input  logic        cfg_idx,
    input  logic [7:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN = 4'd1;
    localparam logic [3:0] ST_CHK0 = 4'd2;
    localparam logic [3:0] ST_HDR3 = 4'd3;
    localparam logic [3:0] ST_HDR4 = 4'd4;
    localparam logic [3:0] ST_CRC  = 4'd5;
    localparam logic [3:0] ST_CKL  = 4'd6;
    localparam logic [3:0] ST_CKH  = 4'd7;
    localparam logic [3:0] ST_PAY  = 4'd8;
    localparam logic [3:0] ST_EMRD = 4'd9;
    localparam logic [3:0] ST_EMLD = 4'd10;
    localparam logic [3:0] ST_EMWT = 4'd11;

    localparam int AW = frs_pkg::STORE_AW;

    logic [3:0]   state_reg, state_next;
    logic [7:0]   start_reg, start_next;
    logic [5:0]   limit_reg, limit_next;
    logic [AW-1:0] fill_reg, fill_next;
    logic [31:0]  resync_reg, resync_next;
    logic [31:0]  good_reg, good_next;
    logic [31:0]  bad_reg, bad_next;
    logic [5:0]   n_reg, n_next;
    logic [AW-1:0] j_reg, j_next;
    logic [5:0]   k_reg, k_next;
    logic [5:0]   len_reg, len_next;
    logic [7:0]   lo_reg, lo_next;
    logic [7:0]   ver_reg, ver_next;
    logic [7:0]   typ_reg, typ_next;
    logic [7:0]   want_lo_reg, want_lo_next;
    logic [15:0]  crc_reg, crc_next;

    logic                 ov_reg, ov_next;
    logic                 ok_reg, ok_next;
    frs_pkg::res_entry_t  oe_reg, oe_next;
    logic                 of_reg, of_next;

    frs_pkg::store_req_t  sreq;
    logic [7:0]           sdata;
    logic                 rb_we;
    frs_pkg::res_entry_t  rb_wdata;
    frs_pkg::res_entry_t  rb_rdata;

    logic [5:0]    lim;
    logic [AW-1:0] total;
    logic [AW-1:0] last_j;

    assign lim    = (limit_reg > 6'(frs_pkg::LIM_CAP)) ? 6'(frs_pkg::LIM_CAP) : limit_reg;
    assign total  = AW'(len_reg) + AW'(frs_pkg::OVERHEAD);
    assign last_j = AW'(len_reg) + AW'(frs_pkg::HDR_BYTES - 1);

    frs_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (sreq),
        .rd_data (sdata)
    );

    frs_resbuf u_resbuf
    (
        .clk     (clk),
        .wr_en   (rb_we),
        .wr_addr (n_reg[frs_pkg::RES_AW-1:0]),
        .wr_data (rb_wdata),
        .rd_addr (k_reg[frs_pkg::RES_AW-1:0]),
        .rd_data (rb_rdata)
    );

    // configuration
    always_comb
    begin
        start_next = start_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                frs_pkg::REG_START_BYTE:    start_next = cfg_data;
                frs_pkg::REG_PAYLOAD_LIMIT: limit_next = cfg_data[5:0];
                default:                    start_next = start_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        resync_next  = resync_reg;
        good_next    = good_reg;
        bad_next     = bad_reg;
        n_next       = n_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        lo_next      = lo_reg;
        ver_next     = ver_reg;
        typ_next     = typ_reg;
        want_lo_next = want_lo_reg;
        crc_next     = crc_reg;
        ov_next      = ov_reg;
        ok_next      = ok_reg;
        oe_next      = oe_reg;
        of_next      = of_reg;

        sreq          = '0;
        sreq.wr_data  = rx.rx_byte;
        rb_we         = 1'b0;
        rb_wdata      = '0;
        rb_wdata.frame_version = ver_reg;
        rb_wdata.frame_type    = typ_reg;
        rb_wdata.frame_length  = len_reg;
        rb_wdata.byte_index    = 5'(j_reg - AW'(frs_pkg::HDR_BYTES));
        rb_wdata.payload_byte  = sdata;
        rb_wdata.payload_valid = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx.valid)
                begin
                    sreq.wr_en  = 1'b1;
                    sreq.wr_idx = (fill_reg >= AW'(frs_pkg::STORE_DEPTH)) ? '0 : fill_reg;
                    fill_next   = sreq.wr_idx + AW'(1);
                    n_next      = '0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                sreq.rd_idx = '0;
                state_next  = (fill_reg == '0) ? ST_EMRD : ST_CHK0;
                k_next      = '0;
            end
            ST_CHK0:
            begin
                sreq.rd_idx = AW'(3);
                if (sdata != start_reg)
                begin
                    resync_next   = resync_reg + 32'd1;
                    sreq.drop_en  = 1'b1;
                    sreq.drop_cnt = AW'(1);
                    fill_next     = fill_reg - AW'(1);
                    state_next    = ST_SCAN;
                end
                else if (fill_reg < AW'(frs_pkg::HDR_BYTES))
                    state_next = ST_EMRD;
                else
                    state_next = ST_HDR3;
            end
            ST_HDR3:
            begin
                sreq.rd_idx = AW'(4);
                lo_next     = sdata;
                state_next  = ST_HDR4;
            end
            ST_HDR4:
            begin
                sreq.rd_idx = AW'(1);
                if (sdata != 8'h00 || lo_reg > {2'b00, lim})
                begin
                    bad_next      = bad_reg + 32'd1;
                    sreq.drop_en  = 1'b1;
                    sreq.drop_cnt = AW'(1);
                    fill_next     = fill_reg - AW'(1);
                    state_next    = ST_SCAN;
                end
                else
                begin
                    len_next = lo_reg[5:0];
                    if (fill_reg < AW'(lo_reg[5:0]) + AW'(frs_pkg::OVERHEAD))
                        state_next = ST_EMRD;
                    else
                    begin
                        crc_next   = frs_pkg::CRC_INIT;
                        j_next     = AW'(1);
                        state_next = ST_CRC;
                    end
                end
            end
            ST_CRC:
            begin
                sreq.rd_idx = j_reg + AW'(1);
                crc_next    = frs_pkg::crc_byte(crc_reg, sdata);
                if (j_reg == AW'(1))
                    ver_next = sdata;
                if (j_reg == AW'(2))
                    typ_next = sdata;
                j_next = j_reg + AW'(1);
                if (j_reg == last_j)
                    state_next = ST_CKL;
            end
            ST_CKL:
            begin
                sreq.rd_idx  = total - AW'(1);
                want_lo_next = sdata;
                state_next   = ST_CKH;
            end
            ST_CKH:
            begin
                sreq.rd_idx = AW'(frs_pkg::HDR_BYTES);
                j_next      = AW'(frs_pkg::HDR_BYTES);
                if ({sdata, want_lo_reg} == crc_reg)
                begin
                    good_next = good_reg + 32'd1;
                    if (len_reg == '0)
                    begin
                        if (n_reg < 6'(frs_pkg::RES_DEPTH))
                        begin
                            rb_we                  = 1'b1;
                            rb_wdata.byte_index    = '0;
                            rb_wdata.payload_byte  = '0;
                            rb_wdata.payload_valid = 1'b0;
                            n_next                 = n_reg + 6'd1;
                        end
                        sreq.drop_en  = 1'b1;
                        sreq.drop_cnt = total;
                        fill_next     = fill_reg - total;
                        state_next    = ST_SCAN;
                    end
                    else
                        state_next = ST_PAY;
                end
                else
                begin
                    bad_next      = bad_reg + 32'd1;
                    sreq.drop_en  = 1'b1;
                    sreq.drop_cnt = AW'(1);
                    fill_next     = fill_reg - AW'(1);
                    state_next    = ST_SCAN;
                end
            end
            ST_PAY:
            begin
                sreq.rd_idx = j_reg + AW'(1);
                if (n_reg < 6'(frs_pkg::RES_DEPTH))
                begin
                    rb_we  = 1'b1;
                    n_next = n_reg + 6'd1;
                end
                j_next = j_reg + AW'(1);
                if (j_reg == last_j)
                begin
                    sreq.drop_en  = 1'b1;
                    sreq.drop_cnt = total;
                    fill_next     = fill_reg - total;
                    state_next    = ST_SCAN;
                end
            end
            ST_EMRD:
            begin
                if (k_reg == n_reg)
                begin
                    ov_next    = 1'b1;
                    ok_next    = 1'b1;
                    oe_next    = '0;
                    of_next    = 1'b1;
                    state_next = ST_EMWT;
                end
                else
                    state_next = ST_EMLD;
            end
            ST_EMLD:
            begin
                ov_next    = 1'b1;
                ok_next    = 1'b0;
                oe_next    = rb_rdata;
                of_next    = 1'b0;
                state_next = ST_EMWT;
            end
            ST_EMWT:
            begin
                if (result.ready)
                begin
                    ov_next = 1'b0;
                    if (of_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + 6'd1;
                        state_next = ST_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            start_reg  <= 8'hAA;
            limit_reg  <= 6'd32;
            fill_reg   <= '0;
            resync_reg <= '0;
            good_reg   <= '0;
            bad_reg    <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            start_reg  <= start_next;
            limit_reg  <= limit_next;
            fill_reg   <= fill_next;
            resync_reg <= resync_next;
            good_reg   <= good_next;
            bad_reg    <= bad_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            ov_reg     <= ov_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        j_reg       <= j_next;
        len_reg     <= len_next;
        lo_reg      <= lo_next;
        ver_reg     <= ver_next;
        typ_reg     <= typ_next;
        want_lo_reg <= want_lo_next;
        crc_reg     <= crc_next;
        ok_reg      <= ok_next;
        oe_reg      <= oe_next;
        of_reg      <= of_next;
    end

    // ports
    assign rx.ready             = (state_reg == ST_IDLE);
    assign result.valid         = ov_reg;
    assign result.kind          = ok_reg;
    assign result.frame_version = oe_reg.frame_version;
    assign result.frame_type    = oe_reg.frame_type;
    assign result.frame_length  = oe_reg.frame_length;
    assign result.byte_index    = oe_reg.byte_index;
    assign result.payload_byte  = oe_reg.payload_byte;
    assign result.payload_valid = oe_reg.payload_valid;
    assign result.final_res     = of_reg;
    assign result.resync_total  = resync_reg;
    assign result.good_total    = good_reg;
    assign result.bad_total     = bad_reg;

    // checks
    a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        rx.ready |-> !result.valid) else $error("input ready while result pending");
    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= 6'(frs_pkg::RES_DEPTH)) else $error("result count overflow");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= AW'(frs_pkg::STORE_DEPTH)) else $error("fill beyond store");
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && result.final_res |=> rx.ready)
        else $error("not idle after status beat");

endmodule
